// ----- sv/length_prefixed_row_deframer_top_defines.svh -----
`ifndef LENGTH_PREFIXED_ROW_DEFRAMER_TOP_DEFINES_SVH
`define LENGTH_PREFIXED_ROW_DEFRAMER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPRD_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lprd check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LPRD_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lprd check failed");

`endif

// ----- sv/lprd_pkg.sv -----
`timescale 1ns / 1ps

package lprd_pkg;

    localparam int SIZE_WORD_BYTES_DEF = 8;
    localparam int POSITION_BITS_DEF   = 32;

    typedef enum logic [1:0] {
        PH_KSIZE = 2'd0,
        PH_KSKIP = 2'd1,
        PH_RSIZE = 2'd2,
        PH_RSKIP = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_ROW = 2'd0,
        KIND_END = 2'd1,
        KIND_ERR = 2'd2
    } kind_t;

    typedef struct packed {
        logic [31:0] block_length;
        logic        first_of_block;
        logic [7:0]  data_byte;
    } item_t;

    typedef struct packed {
        kind_t       result_kind;
        logic [31:0] row_offset;
        logic [31:0] row_length;
        logic        last;
    } result_t;

    // Up to two results produced by one byte, res0 first.
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } push_t;

endpackage

// ----- sv/lprd_in_stage.sv -----
`timescale 1ns / 1ps

module lprd_in_stage
    import lprd_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  item_t s_item,
    input  logic  take,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Refill in the same cycle the held item moves on.
    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

endmodule

// ----- sv/lprd_core.sv -----
`timescale 1ns / 1ps

module lprd_core
    import lprd_pkg::*;
#(
    parameter int SIZE_WORD_BYTES = SIZE_WORD_BYTES_DEF,
    parameter int POSITION_BITS   = POSITION_BITS_DEF
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  cfg_we,
    input  logic  cfg_wdata,
    input  logic  advance,
    input  item_t item,
    output push_t push
);

    localparam int SW      = 8 * SIZE_WORD_BYTES;
    localparam int CW      = (POSITION_BITS > 32) ? POSITION_BITS : 32;
    localparam int ZW      = (SW > 32) ? SW : 32;
    localparam int WBC_W   = (SIZE_WORD_BYTES > 1) ? $clog2(SIZE_WORD_BYTES) : 1;
    localparam int WBC_I_W = WBC_W + 1;

    logic                     kpp_reg;
    phase_t                   phase_reg, phase_next;
    logic [WBC_W-1:0]         wbc_reg, wbc_next;
    logic [SW-1:0]            size_reg, size_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [31:0]              rem_reg, rem_next;
    logic [31:0]              skip_reg, skip_next;
    logic [31:0]              row_len_reg, row_len_next;
    logic                     err_reg, err_next;

    phase_t                   start_phase;
    phase_t                   b_phase;
    logic [WBC_W-1:0]         b_wbc;
    logic [POSITION_BITS-1:0] b_pos;
    logic [31:0]              b_rem;
    logic [31:0]              b_skip;
    logic                     b_err;

    logic                     first;
    logic [CW-1:0]            blen_ext;
    logic [CW-1:0]            newpos_ext;
    logic [POSITION_BITS-1:0] newpos;
    logic                     active;
    logic                     is_size;
    logic [SW-1:0]            size_word;
    logic [WBC_I_W-1:0]       wbc_inc;
    logic                     word_done;
    logic [ZW-1:0]            sz_ext;
    logic [31:0]              sz32;
    logic                     size_err;
    logic [31:0]              skip_dec;
    logic                     row_hit;
    logic                     end_hit;
    logic [31:0]              row_len_out;
    logic [POSITION_BITS-1:0] row_off_pos;
    logic [31:0]              row_off;
    logic [31:0]              restart_rem;

    // Little-endian size word: shift each byte in from the top.
    generate
        if (SW == 8) begin : g_one_byte
            assign size_word = item.data_byte;
        end else begin : g_multi_byte
            assign size_word = {item.data_byte, size_reg[SW-1:8]};
        end
    endgenerate

    // Decode the byte against the state, with a block start applied first.
    always_comb begin
        first       = item.first_of_block;
        start_phase = kpp_reg ? PH_KSIZE : PH_RSIZE;
        b_phase     = first ? start_phase : phase_reg;
        b_wbc       = first ? '0 : wbc_reg;
        b_pos       = first ? '0 : pos_reg;
        b_rem       = first ? item.block_length : rem_reg;
        b_skip      = first ? '0 : skip_reg;
        b_err       = first ? 1'b0 : err_reg;

        blen_ext    = CW'(item.block_length);
        active      = advance && !b_err && !(CW'(b_pos) >= blen_ext);
        newpos      = b_pos + POSITION_BITS'(1);
        newpos_ext  = CW'(newpos);

        is_size     = (b_phase == PH_KSIZE) || (b_phase == PH_RSIZE);
        wbc_inc     = WBC_I_W'(b_wbc) + WBC_I_W'(1);
        word_done   = is_size && (wbc_inc == WBC_I_W'(SIZE_WORD_BYTES));
        sz_ext      = ZW'(size_word);
        sz32        = 32'(sz_ext);
        size_err    = word_done && (sz_ext > ZW'(b_rem));
        skip_dec    = b_skip - 32'd1;

        row_hit     = (word_done && !size_err && (b_phase == PH_RSIZE) && (sz32 == '0))
                   || (!is_size && (b_phase == PH_RSKIP) && (skip_dec == '0));
        end_hit     = !size_err && (newpos_ext == blen_ext);

        row_len_out = is_size ? '0 : row_len_reg;
        row_off_pos = newpos - POSITION_BITS'(row_len_out);
        row_off     = 32'(row_off_pos);
        restart_rem = (newpos_ext <= blen_ext) ? 32'(blen_ext - newpos_ext) : '0;
    end

    // Next state
    always_comb begin
        phase_next   = b_phase;
        wbc_next     = b_wbc;
        size_next    = size_reg;
        pos_next     = b_pos;
        rem_next     = b_rem;
        skip_next    = b_skip;
        row_len_next = row_len_reg;
        err_next     = b_err;
        if (!advance) begin
            phase_next = phase_reg;
            wbc_next   = wbc_reg;
            pos_next   = pos_reg;
            rem_next   = rem_reg;
            skip_next  = skip_reg;
            err_next   = err_reg;
        end else if (active) begin
            pos_next = newpos;
            if (is_size) begin
                size_next = size_word;
                if (word_done) begin
                    wbc_next = '0;
                    if (size_err) begin
                        err_next = 1'b1;
                    end else begin
                        skip_next = sz32;
                        if (b_phase == PH_KSIZE) begin
                            phase_next = (sz32 == '0) ? PH_RSIZE : PH_KSKIP;
                        end else if (sz32 != '0) begin
                            row_len_next = sz32;
                            phase_next   = PH_RSKIP;
                        end
                    end
                end else begin
                    wbc_next = wbc_inc[WBC_W-1:0];
                end
            end else begin
                skip_next = skip_dec;
                if ((skip_dec == '0) && (b_phase == PH_KSKIP)) begin
                    phase_next = PH_RSIZE;
                end
            end
            // Start the next record right after a row closes.
            if (row_hit) begin
                phase_next = start_phase;
                wbc_next   = '0;
                skip_next  = '0;
                rem_next   = restart_rem;
            end
            if (end_hit && !row_hit) begin
                err_next = 1'b1;
            end
        end
    end

    // Outputs
    always_comb begin
        push      = '0;
        push.res0 = '{result_kind: KIND_ROW, row_offset: row_off,
                      row_length: row_len_out, last: 1'b1};
        push.res1 = '{result_kind: KIND_END, row_offset: '0,
                      row_length: '0, last: 1'b1};
        if (active) begin
            if (size_err) begin
                push.count = 2'd1;
                push.res0  = '{result_kind: KIND_ERR, row_offset: '0,
                               row_length: '0, last: 1'b1};
            end else if (row_hit && end_hit) begin
                push.count     = 2'd2;
                push.res0.last = 1'b0;
            end else if (row_hit) begin
                push.count = 2'd1;
            end else if (end_hit) begin
                push.count = 2'd1;
                push.res0  = '{result_kind: KIND_ERR, row_offset: '0,
                               row_length: '0, last: 1'b1};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kpp_reg   <= 1'b0;
            phase_reg <= PH_RSIZE;
            wbc_reg   <= '0;
            pos_reg   <= '0;
            rem_reg   <= '0;
            skip_reg  <= '0;
            err_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                kpp_reg <= cfg_wdata;
            end
            phase_reg <= phase_next;
            wbc_reg   <= wbc_next;
            pos_reg   <= pos_next;
            rem_reg   <= rem_next;
            skip_reg  <= skip_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        size_reg    <= size_next;
        row_len_reg <= row_len_next;
    end

endmodule

// ----- sv/lprd_out_queue.sv -----
`timescale 1ns / 1ps

module lprd_out_queue
    import lprd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  push_t   push,
    output logic    push_ready,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_result
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    result_t          q_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pop;
    logic [PTR_W-1:0] wr_ptr_1;

    // Keep room for the two results one byte may produce.
    assign push_ready = (cnt_reg <= CNT_W'(DEPTH - 2));
    assign m_valid    = (cnt_reg != '0);
    assign m_result   = q_reg[rd_ptr_reg];
    assign pop        = m_valid && m_ready;
    assign wr_ptr_1   = wr_ptr_reg + PTR_W'(1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            q_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.count == 2'd2) begin
            q_reg[wr_ptr_1] <= push.res1;
        end
    end

endmodule

// ----- sv/length_prefixed_row_deframer_top.sv -----
`timescale 1ns / 1ps

// Row deframer for a length-prefixed block, one byte per item on the s_ side. Each
// record is an optional key-size word plus key bytes (enabled by cfg_wdata written
// through cfg_we, taken at the start of each record), then a row-size word plus the
// row bytes; size words are little-endian. Each row is reported as offset and length,
// an exactly consumed block as a clean end, and a size that overruns the block or a
// block that stops mid-record as a format error, after which bytes are dropped until
// the next item flagged as block start. Bytes are taken at one per clock while the result
// queue has room; an accepted byte is held in the input register, and its results are
// written into the result queue, from which they show on the m_ side. A four-entry result
// queue sets the rate when m_tready stalls: with a byte held in the input register,
// s_tready drops while more than two results wait, and a row that closes exactly on
// the block end adds a second result.
module length_prefixed_row_deframer_top
    import lprd_pkg::*;
#(
    parameter int SIZE_WORD_BYTES = SIZE_WORD_BYTES_DEF,
    parameter int POSITION_BITS   = POSITION_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // data_byte [7:0], block_length [39:8]
    input  logic        s_tuser,   // first_of_block
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // row_offset [31:0], row_length [63:32]
    output logic [1:0]  m_tuser,   // result_kind
    output logic        m_tlast
);

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    q_ready;
    logic    advance;
    push_t   push;
    result_t m_result;

    assign s_item.data_byte      = s_tdata[7:0];
    assign s_item.block_length   = s_tdata[39:8];
    assign s_item.first_of_block = s_tuser;
    assign advance               = item_valid && q_ready;

    lprd_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .take       (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    lprd_core #(
        .SIZE_WORD_BYTES (SIZE_WORD_BYTES),
        .POSITION_BITS   (POSITION_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .advance   (advance),
        .item      (item),
        .push      (push)
    );

    lprd_out_queue u_out_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_ready (q_ready),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_result   (m_result)
    );

    assign m_tdata = {m_result.row_length, m_result.row_offset};
    assign m_tuser = m_result.result_kind;
    assign m_tlast = m_result.last;

endmodule

// ----- sv/lprd_checker.sv -----
`timescale 1ns / 1ps
`include "length_prefixed_row_deframer_top_defines.svh"

module lprd_checker
    import lprd_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // A stalled result holds.
    `LPRD_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    `LPRD_ASSERT_IMP(a_kind_legal, aclk, aresetn, m_tvalid, m_tuser == KIND_ROW || m_tuser == KIND_END || m_tuser == KIND_ERR)

    // End and error results carry no row and always close the byte.
    `LPRD_ASSERT_IMP(a_status_clean, aclk, aresetn, m_tvalid && m_tuser != KIND_ROW, m_tdata == 64'd0 && m_tlast)

    // A row that is not last is followed at once by the clean end.
    `LPRD_ASSERT_NXT(a_row_then_end, aclk, aresetn, m_tvalid && m_tready && m_tuser == KIND_ROW && !m_tlast, m_tvalid && m_tuser == KIND_END)

endmodule

bind length_prefixed_row_deframer_top lprd_checker u_lprd_checker (.*);

// ----- verif/length_prefixed_row_deframer_top_tb.sv -----
`timescale 1ns / 1ps

module length_prefixed_row_deframer_top_tb;
    import lprd_pkg::*;

    localparam int WORD_BYTES      = SIZE_WORD_BYTES_DEF;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 225;
    localparam int PREDICTED       = -1;
    localparam int DIR_ROWS        = 21;

    localparam result_t NO_RESULT      = '0;
    localparam result_t FORMAT_ERROR   = '{KIND_ERR, 32'd0, 32'd0, 1'b1};
    localparam result_t CLEAN_END      = '{KIND_END, 32'd0, 32'd0, 1'b1};
    localparam result_t EMPTY_ROW_AT_8 = '{KIND_ROW, 32'd8, 32'd0, 1'b0};

    typedef struct {
        logic [7:0]  data;
        logic        first;
        logic [31:0] blen;
        int          nres;   // PREDICTED: results come from the predictor
        result_t     r0;
        result_t     r1;
    } stim_row_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    length_prefixed_row_deframer_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Deframer state as seen by the predictor
    phase_t      cur_phase;
    int          word_bytes_seen;
    logic [63:0] size_acc;
    logic [31:0] byte_pos;
    logic [31:0] record_left;
    logic [31:0] skip_left;
    bit          error_hold;
    bit          key_cfg;

    result_t     expected_results[$];
    stim_row_t   sent_rows[$];
    logic [7:0]  carry_bytes[$];
    logic [31:0] carry_blen;

    int  mismatches    = 0;
    int  rows_seen     = 0;
    int  ends_seen     = 0;
    int  errors_seen   = 0;
    int  items_counted = 0;
    int  blocks_sent   = 0;
    int  cycle_count   = 0;
    bit  source_calm   = 1'b0;
    int  sink_hold     = 0;
    int  sink_calm     = 0;
    bit  phase_cfg [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

    stim_row_t dir_rows [DIR_ROWS] = '{
        // bytes ahead of any block start: empty row, then a clean end on the same byte
        '{8'h00, 1'b0, 32'd8, PREDICTED, NO_RESULT, NO_RESULT},
        '{8'h00, 1'b0, 32'd8, PREDICTED, NO_RESULT, NO_RESULT},
        '{8'h00, 1'b0, 32'd8, PREDICTED, NO_RESULT, NO_RESULT},
        '{8'h00, 1'b0, 32'd8, PREDICTED, NO_RESULT, NO_RESULT},
        '{8'h00, 1'b0, 32'd8, PREDICTED, NO_RESULT, NO_RESULT},
        '{8'h00, 1'b0, 32'd8, PREDICTED, NO_RESULT, NO_RESULT},
        '{8'h00, 1'b0, 32'd8, PREDICTED, NO_RESULT, NO_RESULT},
        '{8'h00, 1'b0, 32'd8, 2, EMPTY_ROW_AT_8, CLEAN_END},
        // past the end, then an empty block
        '{8'hFF, 1'b0, 32'd8, 0, NO_RESULT, NO_RESULT},
        '{8'hA5, 1'b1, 32'd0, 0, NO_RESULT, NO_RESULT},
        // all-ones size in a maximal block overruns it
        '{8'hFF, 1'b1, 32'hFFFF_FFFF, PREDICTED, NO_RESULT, NO_RESULT},
        '{8'hFF, 1'b0, 32'hFFFF_FFFF, PREDICTED, NO_RESULT, NO_RESULT},
        '{8'hFF, 1'b0, 32'hFFFF_FFFF, PREDICTED, NO_RESULT, NO_RESULT},
        '{8'hFF, 1'b0, 32'hFFFF_FFFF, PREDICTED, NO_RESULT, NO_RESULT},
        '{8'hFF, 1'b0, 32'hFFFF_FFFF, PREDICTED, NO_RESULT, NO_RESULT},
        '{8'hFF, 1'b0, 32'hFFFF_FFFF, PREDICTED, NO_RESULT, NO_RESULT},
        '{8'hFF, 1'b0, 32'hFFFF_FFFF, PREDICTED, NO_RESULT, NO_RESULT},
        '{8'hFF, 1'b0, 32'hFFFF_FFFF, 1, FORMAT_ERROR, NO_RESULT},
        '{8'h00, 1'b0, 32'hFFFF_FFFF, 0, NO_RESULT, NO_RESULT},
        // block ends inside a size word
        '{8'h01, 1'b1, 32'd2, PREDICTED, NO_RESULT, NO_RESULT},
        '{8'h00, 1'b0, 32'd2, 1, FORMAT_ERROR, NO_RESULT}
    };

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic result_t make_result(kind_t kind, logic [31:0] off, logic [31:0] len,
                                            logic lst);
        result_t r;
        r.result_kind = kind;
        r.row_offset  = off;
        r.row_length  = len;
        r.last        = lst;
        return r;
    endfunction

    function automatic void clear_deframer();
        key_cfg         = 1'b0;
        cur_phase       = PH_RSIZE;
        word_bytes_seen = 0;
        size_acc        = '0;
        byte_pos        = '0;
        record_left     = '0;
        skip_left       = '0;
        error_hold      = 1'b0;
    endfunction

    function automatic void open_record(logic [31:0] blen, logic [31:0] p);
        cur_phase       = key_cfg ? PH_KSIZE : PH_RSIZE;
        word_bytes_seen = 0;
        size_acc        = '0;
        skip_left       = '0;
        record_left     = (p <= blen) ? blen - p : 32'd0;
    endfunction

    function automatic void deframe_byte(input logic [7:0] b, input logic first,
                                         input logic [31:0] blen, output int n,
                                         output result_t r0, output result_t r1);
        logic [31:0] nxt;
        logic [63:0] sz;
        logic [31:0] roff;
        logic [31:0] rlen;
        bit          closed;
        bit          row_hit;
        result_t     tail;
        n       = 0;
        r0      = NO_RESULT;
        r1      = NO_RESULT;
        closed  = 1'b0;
        row_hit = 1'b0;
        roff    = '0;
        rlen    = '0;
        if (first) begin
            byte_pos   = '0;
            error_hold = 1'b0;
            open_record(blen, 32'd0);
        end
        if (error_hold || byte_pos >= blen) return;
        nxt = byte_pos + 32'd1;
        if (cur_phase == PH_KSIZE || cur_phase == PH_RSIZE) begin
            size_acc = size_acc | (64'(b) << (8 * word_bytes_seen));
            word_bytes_seen++;
            if (word_bytes_seen >= WORD_BYTES) begin
                sz              = size_acc;
                word_bytes_seen = 0;
                size_acc        = '0;
                if (sz > 64'(record_left)) begin
                    error_hold = 1'b1;
                    byte_pos   = nxt;
                    n          = 1;
                    r0         = FORMAT_ERROR;
                    return;
                end
                skip_left = sz[31:0];
                if (cur_phase == PH_KSIZE) begin
                    cur_phase = (skip_left == 0) ? PH_RSIZE : PH_KSKIP;
                end else if (skip_left == 0) begin
                    row_hit = 1'b1;
                    roff    = nxt;
                    closed  = 1'b1;
                end else begin
                    // keep the row size for the report at the last row byte
                    size_acc  = sz;
                    cur_phase = PH_RSKIP;
                end
            end
        end else begin
            skip_left--;
            if (skip_left == 0) begin
                if (cur_phase == PH_KSKIP) begin
                    cur_phase = PH_RSIZE;
                end else begin
                    row_hit = 1'b1;
                    rlen    = size_acc[31:0];
                    roff    = nxt - rlen;
                    closed  = 1'b1;
                end
            end
        end
        byte_pos = nxt;
        if (closed) open_record(blen, nxt);
        if (row_hit) begin
            r0 = make_result(KIND_ROW, roff, rlen, 1'b1);
            n  = 1;
        end
        if (nxt == blen) begin
            if (n > 0) r0.last = 1'b0;
            if (closed) begin
                tail = CLEAN_END;
            end else begin
                error_hold = 1'b1;
                tail       = FORMAT_ERROR;
            end
            if (n == 0) r0 = tail;
            else r1 = tail;
            n++;
        end
    endfunction

    always @(posedge aclk) begin : scoreboard
        result_t   got;
        result_t   want;
        result_t   p0;
        result_t   p1;
        stim_row_t row;
        int        n;
        if (!aresetn) begin
            clear_deframer();
        end else begin
            if (cfg_we) key_cfg = cfg_wdata;
            if (m_tvalid && m_tready) begin
                got = make_result(kind_t'(m_tuser), m_tdata[31:0], m_tdata[63:32], m_tlast);
                case (got.result_kind)
                    KIND_ROW: rows_seen++;
                    KIND_END: ends_seen++;
                    default:  errors_seen++;
                endcase
                if (expected_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, got kind %0d off %0d len %0d last %0b",
                             $time, got.result_kind, got.row_offset, got.row_length, got.last);
                end else begin
                    want = expected_results.pop_front();
                    if (got.result_kind !== want.result_kind || got.row_offset !== want.row_offset ||
                        got.row_length !== want.row_length || got.last !== want.last) begin
                        mismatches++;
                        $display("%0t: mismatch, expected kind %0d off %0d len %0d last %0b, got kind %0d off %0d len %0d last %0b",
                                 $time, want.result_kind, want.row_offset, want.row_length,
                                 want.last, got.result_kind, got.row_offset, got.row_length,
                                 got.last);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                deframe_byte(s_tdata[7:0], s_tuser, s_tdata[39:8], n, p0, p1);
                if (sent_rows.size() > 0) begin
                    row = sent_rows.pop_front();
                    // typed-in rows override the predictor's results
                    if (row.nres != PREDICTED) begin
                        n  = row.nres;
                        p0 = row.r0;
                        p1 = row.r1;
                    end
                end
                if (n > 0) expected_results.push_back(p0);
                if (n > 1) expected_results.push_back(p1);
            end
        end
    end

    // Result-side backpressure: mostly short stalls, a few long, calm stretches in between
    always @(posedge aclk) begin
        if (sink_calm > 0) sink_calm--;
        else if ($urandom_range(0, 499) == 0) sink_calm = $urandom_range(50, 300);
        if (sink_hold > 0) begin
            sink_hold--;
            m_tready <= 1'b0;
        end else if (sink_calm == 0 && $urandom_range(0, 99) < 20) begin
            sink_hold = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                     : $urandom_range(3, 30);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still expected", $time, expected_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (source_calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    task automatic send_byte(input stim_row_t row);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        sent_rows.push_back(row);
        s_tvalid <= 1'b1;
        s_tdata  <= {row.blen, row.data};
        s_tuser  <= row.first;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_run(input logic [7:0] q[$], input int upto, input bit flag_first,
                            input logic [31:0] blen);
        stim_row_t row;
        row.nres = PREDICTED;
        row.r0   = NO_RESULT;
        row.r1   = NO_RESULT;
        row.blen = blen;
        for (int i = 0; i < upto; i++) begin
            row.data  = q[i];
            row.first = flag_first && (i == 0);
            send_byte(row);
            if (32'(i) < blen) items_counted++;
        end
    endtask

    function automatic void push_size_word(ref logic [7:0] q[$], input logic [63:0] sz);
        for (int i = 0; i < WORD_BYTES; i++) q.push_back(sz[8 * i +: 8]);
    endfunction

    function automatic void build_records(input bit key_on, input int nrec,
                                          ref logic [7:0] q[$]);
        int len;
        int r;
        for (int k = 0; k < nrec; k++) begin
            if (key_on) begin
                len = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 4) : $urandom_range(5, 20);
                push_size_word(q, 64'(len));
                repeat (len) q.push_back(8'($urandom));
            end
            r   = $urandom_range(0, 99);
            len = (r < 15) ? 0 : (r < 85) ? $urandom_range(1, 12) : $urandom_range(13, 60);
            push_size_word(q, 64'(len));
            repeat (len) q.push_back(8'($urandom));
        end
    endfunction

    task automatic send_random_block(input bit key_on);
        logic [7:0]  q[$];
        logic [31:0] blen;
        int          nsend;
        int          r;
        bit          flag_first;
        build_records(key_on, $urandom_range(1, 4), q);
        blen       = 32'(q.size());
        nsend      = q.size();
        flag_first = 1'b1;
        r          = $urandom_range(0, 99);
        if (r < 70) begin
            // well-formed block, nothing to change
        end else if (r < 78) begin
            nsend = $urandom_range(1, q.size());
        end else if (r < 85) begin
            blen = 32'($urandom_range(1, q.size()));
        end else if (r < 90) begin
            q[$urandom_range(0, q.size() - 1)] = 8'($urandom);
        end else if (r < 94) begin
            blen = $urandom | 32'h8000_0000;
        end else if (r < 97) begin
            flag_first = 1'b0;
        end else begin
            q.delete();
            repeat ($urandom_range(1, 12)) q.push_back(8'($urandom));
            nsend = q.size();
            blen  = $urandom;
        end
        source_calm = ($urandom_range(0, 9) == 0);
        send_run(q, nsend, flag_first, blen);
        blocks_sent++;
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0 || sent_rows.size() != 0) @(posedge aclk);
        // a byte that yields nothing may still be in flight
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_key_cfg(input bit value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    initial begin : stimulus
        logic [7:0] q[$];
        int         phase_start;
        int         cut;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_key_cfg(1'b0);

        foreach (dir_rows[i]) send_byte(dir_rows[i]);
        s_tvalid <= 1'b0;
        blocks_sent += 4;

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            write_key_cfg(phase_cfg[p]);
            phase_start = items_counted;
            // finish the record left open across the register write, or drop it
            if (carry_bytes.size() > 0 && $urandom_range(0, 1) == 1)
                send_run(carry_bytes, carry_bytes.size(), 1'b0, carry_blen);
            carry_bytes.delete();
            while (items_counted - phase_start < ITEMS_PER_PHASE)
                send_random_block(phase_cfg[p]);
            q.delete();
            build_records(phase_cfg[p], $urandom_range(2, 3), q);
            cut        = $urandom_range(1, q.size() - 1);
            carry_blen = 32'(q.size());
            send_run(q, cut, 1'b1, carry_blen);
            for (int i = cut; i < q.size(); i++) carry_bytes.push_back(q[i]);
            blocks_sent++;
            s_tvalid <= 1'b0;
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        $display("Sent %0d bytes in %0d blocks across %0d register settings, key prefix on and off.",
                 items_counted, blocks_sent, PHASES + 1);
        $display("Checked %0d rows, %0d clean block ends and %0d format errors.",
                 rows_seen, ends_seen, errors_seen);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
